// ===== hdl/pawc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pawc_pkg: shared types, constants and AES functions
// S-boxes, round functions, key schedule step and frame constants.
// ----------------------------------------------------------------------------
package pawc_pkg;

	localparam int BLK     = 16;
	localparam int HDR_LEN = 6;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 64;

	localparam logic [3:0] NR = 4'd10;

	localparam logic [7:0] TYPE_DEC = 8'h03;
	localparam logic [7:0] TYPE_ENC = 8'h06;

	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_SHORT = 3'd1;
	localparam logic [2:0] ST_ALIGN = 3'd2;
	localparam logic [2:0] ST_LONG  = 3'd3;
	localparam logic [2:0] ST_PAD   = 3'd4;

	localparam logic [1:0] REG_KEY_HI = 2'd0;
	localparam logic [1:0] REG_KEY_LO = 2'd1;
	localparam logic [1:0] REG_LINK   = 2'd2;

	localparam logic [1:0] SRC_GATH = 2'd0;
	localparam logic [1:0] SRC_PAD  = 2'd1;
	localparam logic [1:0] SRC_DEC  = 2'd2;

	typedef logic [127:0] blk_t;

	typedef struct packed {
		logic start;
		logic dec;
	} aes_cmd_t;

	typedef struct packed {
		logic done;
	} aes_rsp_t;

	localparam logic [0:255][7:0] SBOX = {
		128'h637c777bf26b6fc53001672bfed7ab76,
		128'hca82c97dfa5947f0add4a2af9ca472c0,
		128'hb7fd9326363ff7cc34a5e5f171d83115,
		128'h04c723c31896059a071280e2eb27b275,
		128'h09832c1a1b6e5aa0523bd6b329e32f84,
		128'h53d100ed20fcb15b6acbbe394a4c58cf,
		128'hd0efaafb434d338545f9027f503c9fa8,
		128'h51a3408f929d38f5bcb6da2110fff3d2,
		128'hcd0c13ec5f974417c4a77e3d645d1973,
		128'h60814fdc222a908846eeb814de5e0bdb,
		128'he0323a0a4906245cc2d3ac629195e479,
		128'he7c8376d8dd54ea96c56f4ea657aae08,
		128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
		128'h703eb5664803f60e613557b986c11d9e,
		128'he1f8981169d98e949b1e87e9ce5528df,
		128'h8ca1890dbfe6426841992d0fb054bb16
	};

	localparam logic [0:255][7:0] ISBOX = {
		128'h52096ad53036a538bf40a39e81f3d7fb,
		128'h7ce339829b2fff87348e4344c4dee9cb,
		128'h547b9432a6c2233dee4c950b42fac34e,
		128'h082ea16628d924b2765ba2496d8bd125,
		128'h72f8f66486689816d4a45ccc5d65b692,
		128'h6c704850fdedb9da5e154657a78d9d84,
		128'h90d8ab008cbcd30af7e45805b8b34506,
		128'hd02c1e8fca3f0f02c1afbd0301138a6b,
		128'h3a9111414f67dcea97f2cfcef0b4e673,
		128'h96ac7422e7ad3585e2f937e81c75df6e,
		128'h47f11a711d29c5896fb7620eaa18be1b,
		128'hfc563e4bc6d279209adbc0fe78cd5af4,
		128'h1fdda8338807c731b11210592780ec5f,
		128'h60517fa919b54a0d2de57a9f93c99cef,
		128'ha0e03b4dae2af5b0c8ebbb3c83539961,
		128'h172b047eba77d626e169146355210c7d
	};

	function automatic logic [7:0] xt(logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic blk_t sub_blk(blk_t s, logic inv);
		blk_t t;
		for (int i = 0; i < BLK; i++)
			t[127-8*i -: 8] = inv ? ISBOX[s[127-8*i -: 8]] : SBOX[s[127-8*i -: 8]];
		return t;
	endfunction

	function automatic blk_t shift_rows(blk_t s, logic inv);
		blk_t t;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++) begin
				if (inv)
					t[127-8*(((c+r)&3)*4+r) -: 8] = s[127-8*(c*4+r) -: 8];
				else
					t[127-8*(c*4+r) -: 8] = s[127-8*(((c+r)&3)*4+r) -: 8];
			end
		return t;
	endfunction

	function automatic logic [31:0] mix_col(logic [31:0] w, logic inv);
		logic [7:0] a [4];
		logic [7:0] x2 [4];
		logic [7:0] x4 [4];
		logic [7:0] x8 [4];
		logic [7:0] m2 [4];
		logic [7:0] m3 [4];
		logic [7:0] m9 [4];
		logic [7:0] mb [4];
		logic [7:0] md [4];
		logic [7:0] me [4];
		logic [31:0] o;
		for (int k = 0; k < 4; k++) begin
			a[k]  = w[31-8*k -: 8];
			x2[k] = xt(a[k]);
			x4[k] = xt(x2[k]);
			x8[k] = xt(x4[k]);
			m2[k] = x2[k];
			m3[k] = x2[k] ^ a[k];
			m9[k] = x8[k] ^ a[k];
			mb[k] = x8[k] ^ x2[k] ^ a[k];
			md[k] = x8[k] ^ x4[k] ^ a[k];
			me[k] = x8[k] ^ x4[k] ^ x2[k];
		end
		if (inv)
			o = {me[0] ^ mb[1] ^ md[2] ^ m9[3],
			     m9[0] ^ me[1] ^ mb[2] ^ md[3],
			     md[0] ^ m9[1] ^ me[2] ^ mb[3],
			     mb[0] ^ md[1] ^ m9[2] ^ me[3]};
		else
			o = {m2[0] ^ m3[1] ^ a[2] ^ a[3],
			     a[0] ^ m2[1] ^ m3[2] ^ a[3],
			     a[0] ^ a[1] ^ m2[2] ^ m3[3],
			     m3[0] ^ a[1] ^ a[2] ^ m2[3]};
		return o;
	endfunction

	function automatic blk_t mix_blk(blk_t s, logic inv);
		blk_t t;
		for (int c = 0; c < 4; c++)
			t[127-32*c -: 32] = mix_col(s[127-32*c -: 32], inv);
		return t;
	endfunction

	function automatic blk_t enc_round(blk_t s, blk_t rk, logic fin);
		blk_t t;
		t = shift_rows(sub_blk(s, 1'b0), 1'b0);
		if (!fin)
			t = mix_blk(t, 1'b0);
		return t ^ rk;
	endfunction

	function automatic blk_t dec_round(blk_t s, blk_t rk, logic fin);
		blk_t t;
		t = sub_blk(shift_rows(s, 1'b1), 1'b1) ^ rk;
		if (!fin)
			t = mix_blk(t, 1'b1);
		return t;
	endfunction

	function automatic blk_t key_next(blk_t k, logic [7:0] rc);
		logic [31:0] r;
		logic [31:0] t;
		logic [31:0] w0;
		logic [31:0] w1;
		logic [31:0] w2;
		logic [31:0] w3;
		r  = {k[23:0], k[31:24]};
		t  = {SBOX[r[31:24]], SBOX[r[23:16]], SBOX[r[15:8]], SBOX[r[7:0]]} ^ {rc, 24'h0};
		w0 = k[127:96] ^ t;
		w1 = k[95:64] ^ w0;
		w2 = k[63:32] ^ w1;
		w3 = k[31:0] ^ w2;
		return {w0, w1, w2, w3};
	endfunction

	function automatic blk_t pad_blk(blk_t g, logic [3:0] cnt);
		blk_t t;
		logic [7:0] pv;
		pv = {3'b000, 5'd16 - {1'b0, cnt}};
		for (int i = 0; i < BLK; i++)
			t[127-8*i -: 8] = (i < int'(cnt)) ? g[127-8*i -: 8] : pv;
		return t;
	endfunction

	function automatic logic [7:0] blk_byte(blk_t b, logic [3:0] idx);
		blk_t sh;
		sh = b << {idx, 3'b000};
		return sh[127:120];
	endfunction

endpackage

// ===== hdl/pawc_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pawc_regs: configuration register file
// APB-style access to the event key and the link key.
// ----------------------------------------------------------------------------
module pawc_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pawc_pkg::ADDR_W-1:0]  paddr,
	input  logic [pawc_pkg::DATA_W-1:0]  pwdata,
	output logic [pawc_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output pawc_pkg::blk_t               key,
	output logic [31:0]                  link,
	output logic                         key_load
);
	import pawc_pkg::*;

	logic [63:0] key_hi_q;
	logic [63:0] key_lo_q;
	logic [31:0] link_q;
	logic        wr;
	logic [1:0]  idx;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;
	assign idx    = paddr[4:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_hi_q <= '0;
			key_lo_q <= '0;
			link_q   <= '0;
		end else if (wr) begin
			case (idx)
				REG_KEY_HI: key_hi_q <= pwdata;
				REG_KEY_LO: key_lo_q <= pwdata;
				REG_LINK:   link_q   <= pwdata[31:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_KEY_HI: prdata = key_hi_q;
			REG_KEY_LO: prdata = key_lo_q;
			REG_LINK:   prdata = {32'h0, link_q};
			default:    prdata = '0;
		endcase
	end

	assign key      = {key_hi_q, key_lo_q};
	assign link     = link_q;
	assign key_load = wr && (idx == REG_KEY_HI || idx == REG_KEY_LO);

endmodule

// ===== hdl/pawc_aes.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pawc_aes: iterative AES-128 engine
// One round per cycle through a shared round unit; round keys are expanded
// into a key store after each key change, one round key per cycle.
// ----------------------------------------------------------------------------
module pawc_aes (
	input  logic               clk,
	input  logic               arst_n,
	input  pawc_pkg::blk_t     key,
	input  logic               key_load,
	input  pawc_pkg::aes_cmd_t cmd,
	input  pawc_pkg::blk_t     din,
	output pawc_pkg::aes_rsp_t rsp,
	output pawc_pkg::blk_t     dout
);
	import pawc_pkg::*;

	localparam logic [1:0] E_IDLE = 2'd0;
	localparam logic [1:0] E_EXP  = 2'd1;
	localparam logic [1:0] E_LOAD = 2'd2;
	localparam logic [1:0] E_RUN  = 2'd3;

	logic [1:0] est_q;
	logic       stale_q;
	logic       dec_q;
	logic       done_q;
	logic [3:0] cnt_q;
	logic [7:0] rc_q;
	blk_t       kx_q;
	blk_t       st_q;
	blk_t       rk_q [11];
	blk_t       rk_rd;
	blk_t       knx;

	assign rk_rd = rk_q[cnt_q];
	assign knx   = key_next(kx_q, rc_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est_q   <= E_IDLE;
			stale_q <= 1'b1;
			dec_q   <= 1'b0;
			done_q  <= 1'b0;
			cnt_q   <= '0;
			rc_q    <= '0;
			kx_q    <= '0;
			st_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (key_load)
				stale_q <= 1'b1;
			case (est_q)
				E_IDLE: begin
					if (cmd.start) begin
						dec_q <= cmd.dec;
						if (stale_q) begin
							rk_q[0] <= key;
							kx_q    <= key;
							rc_q    <= 8'h01;
							cnt_q   <= 4'd1;
							est_q   <= E_EXP;
						end else begin
							cnt_q <= cmd.dec ? NR : 4'd0;
							est_q <= E_LOAD;
						end
					end
				end
				E_EXP: begin
					rk_q[cnt_q] <= knx;
					kx_q        <= knx;
					rc_q        <= xt(rc_q);
					cnt_q       <= cnt_q + 4'd1;
					if (cnt_q == NR) begin
						stale_q <= 1'b0;
						cnt_q   <= dec_q ? NR : 4'd0;
						est_q   <= E_LOAD;
					end
				end
				E_LOAD: begin
					st_q  <= din ^ rk_rd;
					cnt_q <= dec_q ? NR - 4'd1 : 4'd1;
					est_q <= E_RUN;
				end
				E_RUN: begin
					if (dec_q) begin
						st_q  <= dec_round(st_q, rk_rd, cnt_q == 4'd0);
						cnt_q <= cnt_q - 4'd1;
						if (cnt_q == 4'd0) begin
							done_q <= 1'b1;
							est_q  <= E_IDLE;
						end
					end else begin
						st_q  <= enc_round(st_q, rk_rd, cnt_q == NR);
						cnt_q <= cnt_q + 4'd1;
						if (cnt_q == NR) begin
							done_q <= 1'b1;
							est_q  <= E_IDLE;
						end
					end
				end
				default: est_q <= E_IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign dout     = st_q;

endmodule

// ===== hdl/pdu_aes_whitening_crypt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdu_aes_whitening_crypt: frame crypt unit
// AES-128 ECB with PKCS#7 padding and 4-byte XOR whitening, byte serial.
// ----------------------------------------------------------------------------
// Input beats carry opcode, data_byte and frame_last; output beats carry
// out_byte, out_last and status. Both channels use valid/stall.
// One input beat is handled at a time: in_stall rises after each accepted
// beat and falls when all of that beat's output beats have been produced.
// A beat that completes a 16-byte block runs the round unit (start, load,
// 10 rounds and handover), after a round key expansion when the event key
// changed since the last block; an encrypted block is then sent byte by
// byte, waiting while the receiver stalls.
// Decrypt output lags one byte behind: the last byte leaves with out_last.
// The final output beat of a frame carries status; non-zero means drop.
// A stalled output beat holds, and the sequencer waits before emitting another.
// Reset clears the frame state and marks the round keys for re-expansion.
// Configuration: key_high at 0x00, key_low at 0x08, link_key at 0x10.
// ----------------------------------------------------------------------------
module pdu_aes_whitening_crypt #(
	parameter int MAX_BODY = 128
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pawc_pkg::ADDR_W-1:0]  paddr,
	input  logic [pawc_pkg::DATA_W-1:0]  pwdata,
	output logic [pawc_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         opcode,
	input  logic [7:0]                   data_byte,
	input  logic                         frame_last,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [7:0]                   out_byte,
	output logic                         out_last,
	output logic [2:0]                   status
);
	import pawc_pkg::*;

	localparam int PW = $clog2(MAX_BODY + 2*BLK + HDR_LEN) + 1;
	localparam logic [PW:0] MAXB = (PW+1)'(MAX_BODY);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DISP  = 4'd1;
	localparam logic [3:0] S_HOUT  = 4'd2;
	localparam logic [3:0] S_PUSH1 = 4'd3;
	localparam logic [3:0] S_PUSHH = 4'd4;
	localparam logic [3:0] S_AESGO = 4'd5;
	localparam logic [3:0] S_AESW  = 4'd6;
	localparam logic [3:0] S_EOUT  = 4'd7;
	localparam logic [3:0] S_DLAST = 4'd8;
	localparam logic [3:0] S_FLUSH = 4'd9;
	localparam logic [3:0] S_END   = 4'd10;

	blk_t        key;
	logic [31:0] link;
	logic        key_load;
	aes_cmd_t    cmd;
	aes_rsp_t    rsp;
	blk_t        din;
	blk_t        dout;

	logic [3:0]    st_q;
	logic          op_q;
	logic [7:0]    b_q;
	logic          last_q;
	logic [PW-1:0] pos_q;
	logic          dir_q;
	logic [7:0]    gather_q [BLK];
	logic [3:0]    gc_q;
	blk_t          held_q;
	logic          held_v_q;
	logic [2:0]    fault_q;
	logic [7:0]    pend_q;
	logic          pend_v_q;
	logic [7:0]    byte1_q;
	logic          hl_q;
	logic          hpad_q;
	logic [2:0]    stat_q;
	logic [1:0]    src_q;
	logic          fin_q;
	logic          epad_q;
	logic          dlast_q;
	logic          short_q;
	logic          pmid_q;
	logic [3:0]    idx_q;
	logic [4:0]    lim_q;
	logic          ov_q;
	logic [7:0]    ob_q;
	logic          ol_q;
	logic [2:0]    os_q;

	logic          can_emit;
	logic          dirn;
	logic          hdr;
	logic          full;
	logic [PW-1:0] body;
	logic [PW:0]   body_x;
	logic          over_enc;
	logic          over_dec;
	blk_t          gblk;
	logic [7:0]    pad;

	pawc_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.key      (key),
		.link     (link),
		.key_load (key_load)
	);

	pawc_aes u_aes (
		.clk      (clk),
		.arst_n   (arst_n),
		.key      (key),
		.key_load (key_load),
		.cmd      (cmd),
		.din      (din),
		.rsp      (rsp),
		.dout     (dout)
	);

	always_comb begin
		for (int i = 0; i < BLK; i++)
			gblk[127-8*i -: 8] = gather_q[i];
	end

	assign can_emit = !ov_q || !out_stall;
	assign dirn     = (pos_q == '0) ? op_q : dir_q;
	assign hdr      = pos_q < PW'(HDR_LEN);
	assign full     = gc_q == 4'hf;
	assign body     = pos_q - PW'(HDR_LEN - 1);
	assign body_x   = {1'b0, body};
	assign over_enc = (body_x + (PW+1)'(BLK)) > MAXB;
	assign over_dec = body_x > MAXB;
	assign pad      = held_q[7:0];

	assign cmd.start = st_q == S_AESGO;
	assign cmd.dec   = src_q == SRC_DEC;

	always_comb begin
		case (src_q)
			SRC_GATH: din = gblk;
			SRC_PAD:  din = pad_blk(gblk, gc_q);
			SRC_DEC:  din = gblk ^ {link, link, link, link};
			default:  din = gblk;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_IDLE;
			op_q     <= 1'b0;
			b_q      <= '0;
			last_q   <= 1'b0;
			pos_q    <= '0;
			dir_q    <= 1'b0;
			gc_q     <= '0;
			held_q   <= '0;
			held_v_q <= 1'b0;
			fault_q  <= ST_OK;
			pend_q   <= '0;
			pend_v_q <= 1'b0;
			byte1_q  <= '0;
			hl_q     <= 1'b0;
			hpad_q   <= 1'b0;
			stat_q   <= ST_OK;
			src_q    <= SRC_GATH;
			fin_q    <= 1'b0;
			epad_q   <= 1'b0;
			dlast_q  <= 1'b0;
			short_q  <= 1'b0;
			pmid_q   <= 1'b0;
			idx_q    <= '0;
			lim_q    <= '0;
			ov_q     <= 1'b0;
			ob_q     <= '0;
			ol_q     <= 1'b0;
			os_q     <= ST_OK;
		end else begin
			if (ov_q && !out_stall)
				ov_q <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q   <= opcode;
						b_q    <= data_byte;
						last_q <= frame_last;
						st_q   <= S_DISP;
					end
				end
				S_DISP: begin
					if (pos_q == '0)
						dir_q <= op_q;
					pos_q <= last_q ? '0 : ((pos_q == '1) ? pos_q : pos_q + 1'b1);
					if (hdr) begin
						byte1_q <= (pos_q == '0) ? (dirn ? TYPE_ENC : TYPE_DEC) : b_q;
						if (dirn) begin
							hl_q   <= last_q && pos_q < PW'(HDR_LEN - 1);
							stat_q <= (last_q && pos_q < PW'(HDR_LEN - 1)) ? ST_SHORT : ST_OK;
							hpad_q <= last_q && !(pos_q < PW'(HDR_LEN - 1));
							st_q   <= S_HOUT;
						end else begin
							st_q <= S_PUSH1;
						end
					end else begin
						gather_q[gc_q] <= b_q;
						gc_q           <= gc_q + 4'd1;
						short_q        <= body_x < (PW+1)'(BLK);
						dlast_q        <= last_q;
						if (dirn) begin
							if (full && fault_q == ST_OK && !over_enc) begin
								src_q  <= SRC_GATH;
								fin_q  <= 1'b0;
								epad_q <= last_q;
								st_q   <= S_AESGO;
							end else begin
								if (full && fault_q == ST_OK)
									fault_q <= ST_LONG;
								if (last_q) begin
									if (fault_q != ST_OK || full) begin
										byte1_q <= 8'h00;
										hl_q    <= 1'b1;
										stat_q  <= ST_LONG;
										hpad_q  <= 1'b0;
										st_q    <= S_HOUT;
									end else begin
										src_q  <= SRC_PAD;
										fin_q  <= 1'b1;
										epad_q <= 1'b0;
										st_q   <= S_AESGO;
									end
								end else begin
									st_q <= S_END;
								end
							end
						end else begin
							if (full && fault_q == ST_OK && !over_dec) begin
								src_q <= SRC_DEC;
								if (held_v_q) begin
									idx_q  <= '0;
									lim_q  <= 5'd16;
									pmid_q <= 1'b1;
									st_q   <= S_PUSHH;
								end else begin
									st_q <= S_AESGO;
								end
							end else begin
								if (full && fault_q == ST_OK)
									fault_q <= ST_LONG;
								st_q <= last_q ? S_DLAST : S_END;
							end
						end
					end
				end
				S_HOUT: begin
					if (can_emit) begin
						ov_q <= 1'b1;
						ob_q <= byte1_q;
						ol_q <= hl_q;
						os_q <= stat_q;
						if (hpad_q) begin
							src_q  <= SRC_PAD;
							fin_q  <= 1'b1;
							epad_q <= 1'b0;
							st_q   <= S_AESGO;
						end else begin
							st_q <= S_END;
						end
					end
				end
				S_PUSH1: begin
					if (!pend_v_q || can_emit) begin
						if (pend_v_q) begin
							ov_q <= 1'b1;
							ob_q <= pend_q;
							ol_q <= 1'b0;
							os_q <= ST_OK;
						end
						pend_q   <= byte1_q;
						pend_v_q <= 1'b1;
						if (last_q) begin
							stat_q <= ST_SHORT;
							st_q   <= S_FLUSH;
						end else begin
							st_q <= S_END;
						end
					end
				end
				S_PUSHH: begin
					if (!pend_v_q || can_emit) begin
						if (pend_v_q) begin
							ov_q <= 1'b1;
							ob_q <= pend_q;
							ol_q <= 1'b0;
							os_q <= ST_OK;
						end
						pend_q   <= blk_byte(held_q, idx_q);
						pend_v_q <= 1'b1;
						idx_q    <= idx_q + 4'd1;
						if ({1'b0, idx_q} == lim_q - 5'd1)
							st_q <= pmid_q ? S_AESGO : S_FLUSH;
					end
				end
				S_AESGO: begin
					st_q <= S_AESW;
				end
				S_AESW: begin
					if (rsp.done) begin
						if (src_q == SRC_DEC) begin
							held_q   <= dout;
							held_v_q <= 1'b1;
							st_q     <= dlast_q ? S_DLAST : S_END;
						end else begin
							idx_q <= '0;
							st_q  <= S_EOUT;
						end
					end
				end
				S_EOUT: begin
					if (can_emit) begin
						ov_q  <= 1'b1;
						ob_q  <= blk_byte(dout, idx_q) ^ link[31-8*idx_q[1:0] -: 8];
						ol_q  <= fin_q && idx_q == 4'hf;
						os_q  <= ST_OK;
						idx_q <= idx_q + 4'd1;
						if (idx_q == 4'hf) begin
							if (epad_q) begin
								epad_q <= 1'b0;
								src_q  <= SRC_PAD;
								fin_q  <= 1'b1;
								st_q   <= S_AESGO;
							end else begin
								st_q <= S_END;
							end
						end
					end
				end
				S_DLAST: begin
					idx_q  <= '0;
					pmid_q <= 1'b0;
					lim_q  <= 5'd16 - pad[4:0];
					if (short_q) begin
						stat_q <= ST_SHORT;
						st_q   <= S_FLUSH;
					end else if (gc_q != 4'd0) begin
						stat_q <= ST_ALIGN;
						st_q   <= S_FLUSH;
					end else if (fault_q != ST_OK || !held_v_q) begin
						stat_q <= ST_LONG;
						st_q   <= S_FLUSH;
					end else if (pad == 8'd0 || pad > 8'd16) begin
						stat_q <= ST_PAD;
						st_q   <= S_FLUSH;
					end else begin
						stat_q <= ST_OK;
						st_q   <= (pad == 8'd16) ? S_FLUSH : S_PUSHH;
					end
				end
				S_FLUSH: begin
					if (can_emit) begin
						ov_q     <= 1'b1;
						ob_q     <= pend_v_q ? pend_q : 8'h00;
						ol_q     <= 1'b1;
						os_q     <= stat_q;
						pend_v_q <= 1'b0;
						st_q     <= S_END;
					end
				end
				S_END: begin
					if (last_q) begin
						held_v_q <= 1'b0;
						gc_q     <= '0;
						fault_q  <= ST_OK;
					end
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall  = st_q != S_IDLE;
	assign out_valid = ov_q;
	assign out_byte  = ob_q;
	assign out_last  = ol_q;
	assign status    = os_q;

endmodule

// ===== hdl/pawc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pawc_checker: port-level checks
// Watches the stream ports of the frame crypt unit.
// ----------------------------------------------------------------------------
module pawc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       out_last,
	input logic [2:0] status
);
	import pawc_pkg::*;

	a_status_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> out_last)
		else $error("fault status on a beat that does not end the frame");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == ST_OK || status == ST_SHORT || status == ST_ALIGN ||
		              status == ST_LONG || status == ST_PAD)
		else $error("status code out of range");

	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again before the previous beat was handled");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last)
		                           && $stable(status))
		else $error("stalled output beat changed");

endmodule

bind pdu_aes_whitening_crypt pawc_checker u_pawc_checker (.*);

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: frame crypt unit testbench
// Drives frames of bytes through the input channel and checks every output
// beat against a byte-serial AES-128 ECB / PKCS#7 / whitening predictor.
// Key registers are rewritten through the register port between phases.
// ----------------------------------------------------------------------------
module tb;
	import pawc_pkg::*;

	typedef bit [7:0] st16_t [16];

	typedef struct {
		bit       op;
		bit [7:0] b;
		bit       last;
	} beat_t;

	typedef struct {
		bit [7:0] b;
		bit       last;
		bit [2:0] st;
	} out_beat_t;

	localparam int MAXB = 128;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 0;
	logic in_stall;
	logic opcode = 0;
	logic [7:0] data_byte = 0;
	logic frame_last = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [7:0] out_byte;
	logic out_last;
	logic [2:0] status;

	pdu_aes_whitening_crypt #(.MAX_BODY(MAXB)) uut (.*);

	always #6 clk = ~clk;

	beat_t     frame_beats[$];
	out_beat_t exp_beats[$];
	int        errors = 0;
	bit        quiet = 0;
	bit        hold_req = 0;

	bit [63:0] cfg_key_hi = 0, cfg_key_lo = 0;
	bit [31:0] cfg_link = 0;
	bit [31:0] rkeys [44];

	// crypt unit shadow state
	int unsigned pos_cnt;
	bit          dir;
	st16_t       gath;
	int unsigned gath_cnt;
	st16_t       held;
	bit          held_ok;
	bit [2:0]    fault;
	bit [7:0]    pend_b;
	bit          pend_ok;
	int          step_n;

	function automatic bit [7:0] gmul(bit [7:0] a, bit [7:0] b);
		bit [7:0] p = 0;
		for (int i = 0; i < 8; i++) begin
			if (b[0]) p ^= a;
			a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
			b = b >> 1;
		end
		return p;
	endfunction

	function automatic void expand_keys();
		bit [7:0] rc = 1;
		bit [31:0] t;
		rkeys[0] = cfg_key_hi[63:32];
		rkeys[1] = cfg_key_hi[31:0];
		rkeys[2] = cfg_key_lo[63:32];
		rkeys[3] = cfg_key_lo[31:0];
		for (int i = 4; i < 44; i++) begin
			t = rkeys[i-1];
			if ((i & 3) == 0) begin
				t = {t[23:0], t[31:24]};
				t = {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]} ^ {rc, 24'h0};
				rc = gmul(rc, 8'd2);
			end
			rkeys[i] = rkeys[i-4] ^ t;
		end
	endfunction

	function automatic st16_t add_rk(st16_t s, int rnd);
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				s[c*4+r] ^= 8'(rkeys[rnd*4+c] >> (24 - 8*r));
		return s;
	endfunction

	function automatic st16_t rows(st16_t s, bit inv);
		st16_t t;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				if (inv) t[((c+r)&3)*4+r] = s[c*4+r];
				else t[c*4+r] = s[((c+r)&3)*4+r];
		return t;
	endfunction

	function automatic st16_t cols(st16_t s, bit inv);
		bit [7:0] m [4];
		bit [7:0] a [4];
		if (inv) m = '{8'd14, 8'd11, 8'd13, 8'd9};
		else m = '{8'd2, 8'd3, 8'd1, 8'd1};
		for (int c = 0; c < 4; c++) begin
			for (int k = 0; k < 4; k++) a[k] = s[c*4+k];
			for (int r = 0; r < 4; r++)
				s[c*4+r] = gmul(a[0], m[(4-r)&3]) ^ gmul(a[1], m[(5-r)&3]) ^
				           gmul(a[2], m[(6-r)&3]) ^ gmul(a[3], m[(7-r)&3]);
		end
		return s;
	endfunction

	function automatic st16_t cipher(st16_t s);
		expand_keys();
		s = add_rk(s, 0);
		for (int rnd = 1; rnd <= 10; rnd++) begin
			for (int i = 0; i < 16; i++) s[i] = SBOX[s[i]];
			s = rows(s, 0);
			if (rnd != 10) s = cols(s, 0);
			s = add_rk(s, rnd);
		end
		return s;
	endfunction

	function automatic st16_t inv_cipher(st16_t s);
		expand_keys();
		s = add_rk(s, 10);
		for (int rnd = 9; rnd >= 0; rnd--) begin
			s = rows(s, 1);
			for (int i = 0; i < 16; i++) s[i] = ISBOX[s[i]];
			s = add_rk(s, rnd);
			if (rnd != 0) s = cols(s, 1);
		end
		return s;
	endfunction

	function automatic bit [7:0] link_b(int i);
		return 8'(cfg_link >> (24 - 8*(i & 3)));
	endfunction

	function automatic void put(bit [7:0] b, bit last, bit [2:0] st);
		out_beat_t o;
		if (step_n >= 32) return;
		o.b = b; o.last = last; o.st = st;
		exp_beats.push_back(o);
		step_n++;
	endfunction

	function automatic void lag_push(bit [7:0] b);
		if (pend_ok) put(pend_b, 0, ST_OK);
		pend_b = b;
		pend_ok = 1;
	endfunction

	function automatic void lag_flush(bit [2:0] st);
		put(pend_ok ? pend_b : 8'h00, 1, st);
		pend_ok = 0;
	endfunction

	function automatic void seal_put(st16_t p, bit fin);
		st16_t s;
		s = cipher(p);
		for (int i = 0; i < 16; i++) put(s[i] ^ link_b(i), fin && i == 15, ST_OK);
	endfunction

	function automatic void predict_beat(beat_t it);
		int unsigned body;
		bit [2:0] st;
		bit [7:0] hb, pad;
		st16_t pb;
		step_n = 0;
		if (pos_cnt == 0) begin
			dir = it.op; gath_cnt = 0; held_ok = 0; fault = ST_OK; pend_ok = 0;
		end
		if (pos_cnt < HDR_LEN) begin
			hb = (pos_cnt == 0) ? (dir ? TYPE_ENC : TYPE_DEC) : it.b;
			if (dir) begin
				if (it.last && pos_cnt < HDR_LEN - 1) put(hb, 1, ST_SHORT);
				else begin
					put(hb, 0, ST_OK);
					if (it.last) begin
						foreach (pb[i]) pb[i] = 8'd16;
						seal_put(pb, 1);
					end
				end
			end else begin
				lag_push(hb);
				if (it.last) lag_flush(ST_SHORT);
			end
		end else begin
			body = pos_cnt - HDR_LEN + 1;
			gath[gath_cnt] = it.b;
			gath_cnt = (gath_cnt + 1) & 15;
			if (gath_cnt == 0) begin
				if (dir) begin
					if (fault == ST_OK && body + 16 > MAXB) fault = ST_LONG;
					if (fault == ST_OK) seal_put(gath, 0);
				end else begin
					if (fault == ST_OK && body > MAXB) fault = ST_LONG;
					if (fault == ST_OK) begin
						if (held_ok) for (int i = 0; i < 16; i++) lag_push(held[i]);
						for (int i = 0; i < 16; i++) held[i] = gath[i] ^ link_b(i);
						held = inv_cipher(held);
						held_ok = 1;
					end
				end
			end
			if (it.last) begin
				if (dir) begin
					if (fault != ST_OK) put(8'h00, 1, fault);
					else begin
						pb = gath;
						for (int i = gath_cnt; i < 16; i++) pb[i] = 8'(16 - gath_cnt);
						seal_put(pb, 1);
					end
				end else begin
					if (body < 16) st = ST_SHORT;
					else if (gath_cnt != 0) st = ST_ALIGN;
					else if (fault != ST_OK || !held_ok) st = ST_LONG;
					else begin
						pad = held[15];
						if (pad == 0 || pad > 16) st = ST_PAD;
						else begin
							st = ST_OK;
							for (int i = 0; i < 16 - pad; i++) lag_push(held[i]);
						end
					end
					lag_flush(st);
				end
			end
		end
		if (it.last) pos_cnt = 0;
		else if (pos_cnt < 65535) pos_cnt++;
		if (it.last) begin
			held_ok = 0; gath_cnt = 0; fault = ST_OK;
		end
	endfunction

	// driver
	beat_t cur;
	int    gap_left = 0;
	always @(posedge clk) begin
		beat_t nx;
		if (in_valid && !in_stall) begin
			predict_beat(cur);
			if (!quiet && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 12);
		end
		if (!(in_valid && in_stall)) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 0;
			end else if (frame_beats.size() > 0) begin
				nx = frame_beats.pop_front();
				cur = nx;
				in_valid <= 1;
				opcode <= nx.op;
				data_byte <= nx.b;
				frame_last <= nx.last;
			end else in_valid <= 0;
		end
	end

	// monitor
	int hold_left = 0, burst_left = 0;
	bit hold_seen = 0;
	always @(posedge clk) begin
		out_beat_t e;
		if (out_valid && !out_stall) begin
			if (exp_beats.size() == 0) begin
				errors++;
				$display("%t: unexpected beat byte %h last %b status %0d", $time,
				         out_byte, out_last, status);
			end else begin
				e = exp_beats.pop_front();
				if (out_byte !== e.b) begin
					errors++;
					$display("%t: out_byte expected %h actual %h", $time, e.b, out_byte);
				end
				if (out_last !== e.last) begin
					errors++;
					$display("%t: out_last expected %b actual %b", $time, e.last, out_last);
				end
				if (status !== e.st) begin
					errors++;
					$display("%t: status expected %0d actual %0d", $time, e.st, status);
				end
			end
		end
		if (hold_req && !hold_seen) begin
			hold_seen = 1;
			hold_left = 400;
		end
		if (hold_left > 0) hold_left--;
		else if (burst_left > 0) burst_left--;
		else if (!quiet && $urandom_range(0, 7) == 0) burst_left = $urandom_range(1, 12);
		out_stall <= (hold_left > 0) || (burst_left > 0);
	end

	task automatic reg_write(logic [1:0] idx, bit [63:0] v);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= ADDR_W'(idx) << 3;
		pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		if (idx == REG_KEY_HI) cfg_key_hi = v;
		else if (idx == REG_KEY_LO) cfg_key_lo = v;
		else cfg_link = v[31:0];
	endtask

	task automatic drain();
		while (frame_beats.size() > 0 || in_valid || exp_beats.size() > 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	function automatic void add_beat(bit op, bit [7:0] b, bit last);
		beat_t it;
		it.op = op; it.b = b; it.last = last;
		frame_beats.push_back(it);
	endfunction

	// raw frame: total bytes counting the header, random content
	function automatic void raw_frame(bit op, int total);
		for (int i = 0; i < total; i++)
			add_beat(i == 0 ? op : 1'($urandom), 8'($urandom), i == total - 1);
	endfunction

	// decrypt frame that carries a sealed body; badpad spoils the last pad byte
	function automatic void sealed_frame(int plen, bit badpad);
		bit [7:0] body [$];
		st16_t blk, s;
		int n;
		for (int i = 0; i < plen; i++) body.push_back(8'($urandom));
		n = 16 - (plen % 16);
		for (int i = 0; i < n; i++) body.push_back(8'(n));
		if (badpad) body[body.size()-1] = $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(17, 255));
		add_beat(0, 8'($urandom), 0);
		for (int i = 1; i < HDR_LEN; i++) add_beat(1'($urandom), 8'($urandom), 0);
		for (int k = 0; k < body.size() / 16; k++) begin
			for (int i = 0; i < 16; i++) blk[i] = body[k*16+i];
			s = cipher(blk);
			for (int i = 0; i < 16; i++)
				add_beat(1'($urandom), s[i] ^ link_b(i), k == body.size()/16 - 1 && i == 15);
		end
	endfunction

	task automatic random_phase(int nbeats);
		int base;
		base = frame_beats.size();
		while (frame_beats.size() - base < nbeats) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: sealed_frame($urandom_range(0, 40), 0);
				4:          sealed_frame($urandom_range(0, 40), 1);
				5, 6:       raw_frame(1, $urandom_range(6, 50));
				7:          raw_frame(0, $urandom_range(6, 50));
				default:    raw_frame($urandom_range(0, 1), $urandom_range(1, 8));
			endcase
		end
	endtask

	initial begin
		pos_cnt = 0; dir = 0; gath_cnt = 0; held_ok = 0; fault = ST_OK; pend_ok = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: short frames, empty bodies, key extremes
		raw_frame(1, 1);
		raw_frame(0, 1);
		raw_frame(1, 6);
		raw_frame(0, 3);
		add_beat(0, 8'hff, 0);
		for (int i = 1; i < 5; i++) add_beat(1, 8'h00, 0);
		add_beat(0, 8'hff, 1);
		drain();

		reg_write(REG_KEY_HI, 64'hffff_ffff_ffff_ffff);
		reg_write(REG_KEY_LO, 64'hffff_ffff_ffff_ffff);
		reg_write(REG_LINK, 64'h0000_0000_ffff_ffff);
		sealed_frame(0, 0);
		drain();

		reg_write(REG_KEY_HI, {$urandom, $urandom});
		reg_write(REG_KEY_LO, {$urandom, $urandom});
		reg_write(REG_LINK, {32'h0, $urandom});
		random_phase(10);
		// frames on both sides while the receiver holds off
		hold_req <= 1;
		raw_frame(1, HDR_LEN + 12);
		sealed_frame(12, 0);
		drain();

		reg_write(REG_KEY_HI, 64'h0);
		reg_write(REG_KEY_LO, {$urandom, $urandom});
		reg_write(REG_LINK, 64'h0);
		random_phase(10);
		drain();

		reg_write(REG_KEY_HI, {$urandom, $urandom});
		reg_write(REG_KEY_LO, 64'h0);
		reg_write(REG_LINK, {32'h0, $urandom});
		quiet = 1;
		random_phase(10);
		drain();

		if (errors == 0) $display("Testbench completed without errors");
		else $display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#30ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== pdu_aes_whitening_crypt.f =====
hdl/pawc_pkg.sv
hdl/pawc_regs.sv
hdl/pawc_aes.sv
hdl/pdu_aes_whitening_crypt.sv
hdl/pawc_checker.sv
test/tb.sv
